### rtl/i2c_master_byte_writer_macros.svh
// Assertion macros shared by the I2C master byte writer RTL.
// Depends on nothing; the including module supplies clk and rst.
`ifndef I2C_MASTER_BYTE_WRITER_MACROS_SVH
`define I2C_MASTER_BYTE_WRITER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define I2CMW_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define I2CMW_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### rtl/i2cmw_pkg.sv
// Package for the I2C master byte writer: widths, opcodes, register
// indexes, reset values and the timer clamp function. Depends on nothing.
package i2cmw_pkg;

  localparam int TIMER_WIDTH = 16;
  localparam int CountWidth  = TIMER_WIDTH + 1;
  localparam int RegWidth    = 16;
  localparam int CmpWidth    = 33;
  localparam int BitIdxWidth = 4;

  localparam logic [CmpWidth-1:0] TimerMax = (CmpWidth'(1) << TIMER_WIDTH) - CmpWidth'(1);

  typedef logic [1:0]          opcode_t;
  typedef logic [1:0]          reg_index_t;
  typedef logic [RegWidth-1:0] reg_value_t;
  typedef logic [CountWidth-1:0] count_t;

  localparam opcode_t OP_NONE  = 2'd0;
  localparam opcode_t OP_START = 2'd1;
  localparam opcode_t OP_WRITE = 2'd2;
  localparam opcode_t OP_STOP  = 2'd3;

  localparam reg_index_t REG_EDGE_GAP = 2'd0;
  localparam reg_index_t REG_IDLE_GAP = 2'd1;
  localparam reg_index_t REG_HALF_BIT = 2'd2;

  localparam reg_value_t EDGE_GAP_RESET = 16'd8;
  localparam reg_value_t IDLE_GAP_RESET = 16'd16;
  localparam reg_value_t HALF_BIT_RESET = 16'd4;

  localparam logic [BitIdxWidth-1:0] LAST_BIT_INDEX = 4'd8;

  typedef struct packed {
    logic scl_pull_low;
    logic sda_pull_low;
    logic ready_res;
    logic done_res;
    logic acked;
  } result_t;

  // Limits a register value to the timer range, with an optional floor of one.
  function automatic count_t clamp_target(input reg_value_t v, input logic min_one);
    logic [CmpWidth-1:0] w;
    w = CmpWidth'(v);
    if (w > TimerMax) begin
      w = TimerMax;
    end
    if (min_one && (w == '0)) begin
      w = CmpWidth'(1);
    end
    return CountWidth'(w);
  endfunction

endpackage

### rtl/i2c_master_byte_writer.sv
// I2C master byte writer top level: bus sequencer, configuration registers
// and a two-entry output buffer. Depends on i2cmw_pkg and the macros header.
//
// Usage: every input item is one time tick carrying an opcode (none, start
// with address, write byte, stop), a data byte and the sampled SCL and SDA
// levels. Each accepted item produces exactly one result item: the SCL and
// SDA pull-low drives, ready_res (idle, the next item may carry a command),
// a one-item done_res pulse on completion and acked, valid with done_res.
// Commands arriving while busy are ignored.
// The result of an accepted item is registered into the output register;
// throughput is one item per cycle while in_ready is high, set by the
// single register stage around the sequencer's next-state logic.
// When the receiver stalls, one further item is taken into a skid register
// and in_ready then falls until the receiver drains it; no item is lost.
// Configuration writes take effect at once; the user must make them while
// idle, as the block does not enforce it. Reset idles the sequencer with
// both lines released, restores reset values and empties the output buffer.
`include "i2c_master_byte_writer_macros.svh"

module i2c_master_byte_writer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  i2cmw_pkg::opcode_t   opcode,
  input  logic [7:0]           data_byte,
  input  logic                 scl_line,
  input  logic                 sda_line,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 scl_pull_low,
  output logic                 sda_pull_low,
  output logic                 ready_res,
  output logic                 done_res,
  output logic                 acked,
  input  logic                 cfg_write,
  input  i2cmw_pkg::reg_index_t cfg_index,
  input  i2cmw_pkg::reg_value_t cfg_data
);
  import i2cmw_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START_GAP,
    PH_BIT_LOW,
    PH_BIT_HIGH,
    PH_STOP_SDA,
    PH_STOP_SCL,
    PH_STOP_IDLE
  } phase_t;

  reg_value_t edge_gap_ticks, idle_gap_ticks, half_bit_ticks;

  phase_t                 phase, phase_next;
  opcode_t                command_kind, command_kind_next;
  logic [7:0]             shift_byte, shift_byte_next;
  logic [BitIdxWidth-1:0] bit_index, bit_index_next;
  count_t                 wait_count, wait_count_next;
  logic                   scl_drive, scl_drive_next;
  logic                   sda_drive, sda_drive_next;
  logic                   ack_flag, ack_flag_next;
  logic                   done_next;

  count_t  gap_count, edge_target, idle_target, half_target, high_target;
  result_t result_next;
  result_t out_res, skid_res;
  logic    skid_valid;
  logic    in_accept;

  assign in_ready  = !skid_valid;
  assign in_accept = in_valid && in_ready;

  assign edge_target = clamp_target(edge_gap_ticks, 1'b1);
  assign idle_target = clamp_target(idle_gap_ticks, 1'b1);
  assign half_target = clamp_target(half_bit_ticks, 1'b0);
  assign high_target = clamp_target(half_bit_ticks, 1'b1);
  assign gap_count   = (CmpWidth'(wait_count) < TimerMax) ? wait_count + count_t'(1) : wait_count;

  always_comb begin
    phase_next        = phase;
    command_kind_next = command_kind;
    shift_byte_next   = shift_byte;
    bit_index_next    = bit_index;
    wait_count_next   = wait_count;
    scl_drive_next    = scl_drive;
    sda_drive_next    = sda_drive;
    ack_flag_next     = ack_flag;
    done_next         = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (opcode != OP_NONE) begin
          command_kind_next = opcode;
          wait_count_next   = '0;
          bit_index_next    = '0;
          unique case (opcode)
            OP_START: begin
              shift_byte_next = data_byte;
              sda_drive_next  = 1'b1;
              phase_next      = PH_START_GAP;
            end
            OP_WRITE: begin
              shift_byte_next = data_byte;
              scl_drive_next  = 1'b1;
              phase_next      = PH_BIT_LOW;
            end
            default: begin
              sda_drive_next = 1'b1;
              ack_flag_next  = 1'b0;
              phase_next     = PH_STOP_SDA;
            end
          endcase
        end
      end
      PH_START_GAP: begin
        if (gap_count >= edge_target) begin
          wait_count_next = '0;
          scl_drive_next  = 1'b1;
          phase_next      = PH_BIT_LOW;
        end else begin
          wait_count_next = gap_count;
        end
      end
      PH_BIT_LOW: begin
        if (wait_count > half_target) begin
          if (bit_index >= LAST_BIT_INDEX) begin
            ack_flag_next = !sda_line;
          end
          scl_drive_next  = 1'b0;
          wait_count_next = '0;
          phase_next      = PH_BIT_HIGH;
        end else begin
          if (bit_index >= LAST_BIT_INDEX) begin
            sda_drive_next = 1'b0;
          end else begin
            sda_drive_next = !shift_byte[7];
          end
          wait_count_next = wait_count + count_t'(1);
        end
      end
      PH_BIT_HIGH: begin
        if (scl_line) begin
          if (wait_count + count_t'(1) >= high_target) begin
            scl_drive_next  = 1'b1;
            wait_count_next = '0;
            if (bit_index >= LAST_BIT_INDEX) begin
              bit_index_next = '0;
              done_next      = 1'b1;
              phase_next     = PH_IDLE;
            end else begin
              shift_byte_next = {shift_byte[6:0], 1'b0};
              bit_index_next  = bit_index + BitIdxWidth'(1);
              phase_next      = PH_BIT_LOW;
            end
          end else begin
            wait_count_next = wait_count + count_t'(1);
          end
        end
      end
      PH_STOP_SDA: begin
        if (gap_count >= edge_target) begin
          wait_count_next = '0;
          scl_drive_next  = 1'b0;
          phase_next      = PH_STOP_SCL;
        end else begin
          wait_count_next = gap_count;
        end
      end
      PH_STOP_SCL: begin
        if (gap_count >= edge_target) begin
          wait_count_next = '0;
          sda_drive_next  = 1'b0;
          phase_next      = PH_STOP_IDLE;
        end else begin
          wait_count_next = gap_count;
        end
      end
      PH_STOP_IDLE: begin
        if (gap_count >= idle_target) begin
          wait_count_next = '0;
          done_next       = 1'b1;
          phase_next      = PH_IDLE;
        end else begin
          wait_count_next = gap_count;
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        wait_count_next = '0;
      end
    endcase
  end

  always_comb begin
    result_next.scl_pull_low = scl_drive_next;
    result_next.sda_pull_low = sda_drive_next;
    result_next.ready_res    = (phase_next == PH_IDLE);
    result_next.done_res     = done_next;
    result_next.acked        = done_next && ack_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      command_kind <= OP_NONE;
      shift_byte   <= '0;
      bit_index    <= '0;
      wait_count   <= '0;
      scl_drive    <= 1'b0;
      sda_drive    <= 1'b0;
      ack_flag     <= 1'b0;
    end else if (in_accept) begin
      phase        <= phase_next;
      command_kind <= command_kind_next;
      shift_byte   <= shift_byte_next;
      bit_index    <= bit_index_next;
      wait_count   <= wait_count_next;
      scl_drive    <= scl_drive_next;
      sda_drive    <= sda_drive_next;
      ack_flag     <= ack_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_gap_ticks <= EDGE_GAP_RESET;
      idle_gap_ticks <= IDLE_GAP_RESET;
      half_bit_ticks <= HALF_BIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_EDGE_GAP: edge_gap_ticks <= cfg_data;
        REG_IDLE_GAP: idle_gap_ticks <= cfg_data;
        REG_HALF_BIT: half_bit_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_accept) begin
      if (!out_valid || out_ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_valid && out_ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (!out_valid || out_ready) begin
        out_res <= result_next;
      end else begin
        skid_res <= result_next;
      end
    end else if (out_valid && out_ready && skid_valid) begin
      out_res <= skid_res;
    end
  end

  assign scl_pull_low = out_res.scl_pull_low;
  assign sda_pull_low = out_res.sda_pull_low;
  assign ready_res    = out_res.ready_res;
  assign done_res     = out_res.done_res;
  assign acked        = out_res.acked;

  `I2CMW_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid, "skid entry held with output empty")
  `I2CMW_ASSERT_NOW(a_done_ends_idle, out_valid && done_res, ready_res, "done without idle")
  `I2CMW_ASSERT_NOW(a_ack_with_done, out_valid && acked, done_res, "ack reported without done")
  `I2CMW_ASSERT_NEXT(a_stall_fills_skid, in_accept && out_valid && !out_ready, skid_valid,
    "item taken during stall not held in skid")
  `I2CMW_ASSERT_NOW(a_bit_index_range, 1'b1, bit_index <= LAST_BIT_INDEX,
    "bit index beyond the acknowledge bit")

endmodule
